[design/assert_macros.svh]
// Assertion macros for the checker file cfr_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[design/cfr_pkg.sv]
// Shared constants and controller/datapath interface types for the frame receiver.
package cfr_pkg;

  localparam int MaxLen = 64;
  localparam int ByteW  = 8;
  localparam int LenW   = $clog2(MaxLen + 1);
  localparam int IdxW   = $clog2(MaxLen);

  localparam logic [ByteW-1:0] StartByteRst = 8'd2;

  localparam logic KindByte  = 1'b0;
  localparam logic KindRearm = 1'b1;

  typedef struct packed {
    logic start_clr;
    logic len_load;
    logic data_store;
    logic sum_add;
    logic idx_clr;
    logic rd_issue;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic start_match;
    logic len_ok;
    logic count_done;
    logic sum_zero;
    logic drain_last;
    logic out_free;
  } sts_t;

endpackage

[design/cfr_dp.sv]
// Frame receiver datapath: counters, checksum, payload memory and output register.
module cfr_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [cfr_pkg::ByteW-1:0] cfg_data_i,
  input  logic [cfr_pkg::ByteW-1:0] rx_byte_i,
  input  cfr_pkg::cmd_t            cmd_i,
  output cfr_pkg::sts_t            sts_o,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [cfr_pkg::ByteW-1:0] out_byte_o,
  output logic [cfr_pkg::IdxW-1:0] out_pos_o,
  output logic [cfr_pkg::LenW-1:0] out_len_o,
  output logic                     out_last_o
);
  import cfr_pkg::*;

  logic [ByteW-1:0] start_q;
  logic [LenW-1:0]  count_q, count_inc;
  logic [LenW-1:0]  exp_q;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [IdxW-1:0]  idx_q;
  logic [LenW-1:0]  idx_inc;
  logic [ByteW-1:0] payload_mem [MaxLen];
  logic [ByteW-1:0] rdata_q;
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic [IdxW-1:0]  out_pos_q;
  logic [LenW-1:0]  out_len_q;
  logic             out_last_q;

  assign count_inc = count_q + LenW'(1);
  assign sum_d     = sum_q + rx_byte_i;
  assign idx_inc   = {1'b0, idx_q} + LenW'(1);

  assign sts_o.start_match = (rx_byte_i == start_q);
  assign sts_o.len_ok      = (rx_byte_i != '0) && (rx_byte_i <= ByteW'(MaxLen));
  assign sts_o.count_done  = (count_inc == exp_q);
  assign sts_o.sum_zero    = (sum_d == '0);
  assign sts_o.drain_last  = (idx_inc == exp_q);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= StartByteRst;
      count_q     <= '0;
      exp_q       <= '0;
      sum_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        start_q <= cfg_data_i;
      end
      if (cmd_i.start_clr) begin
        count_q <= '0;
        sum_q   <= '0;
      end else if (cmd_i.data_store) begin
        count_q <= count_inc;
        sum_q   <= sum_d;
      end else if (cmd_i.sum_add) begin
        sum_q <= sum_d;
      end
      if (cmd_i.len_load) begin
        exp_q <= rx_byte_i[LenW-1:0];
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.out_load) begin
        idx_q <= idx_inc[IdxW-1:0];
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.data_store) begin
      payload_mem[count_q[IdxW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.rd_issue) begin
      rdata_q <= payload_mem[idx_q];
    end
    if (cmd_i.out_load) begin
      out_byte_q <= rdata_q;
      out_pos_q  <= idx_q;
      out_len_q  <= exp_q;
      out_last_q <= sts_o.drain_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_pos_o   = out_pos_q;
  assign out_len_o   = out_len_q;
  assign out_last_o  = out_last_q;

endmodule

[design/cfr_ctrl.sv]
// Frame receiver controller: framing state machine, enable flag and drain sequencing.
module cfr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_kind_i,
  output logic          in_ready_o,
  input  cfr_pkg::sts_t sts_i,
  output cfr_pkg::cmd_t cmd_o
);
  import cfr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LENGTH,
    ST_DATA,
    ST_CHECK,
    ST_READ,
    ST_LOAD
  } state_e;

  state_e state_q;
  logic   on_q;
  logic   acc, byte_acc;

  assign in_ready_o = (state_q == ST_IDLE) || (state_q == ST_LENGTH) ||
                      (state_q == ST_DATA) || (state_q == ST_CHECK);
  assign acc        = in_valid_i && in_ready_o;
  assign byte_acc   = acc && (in_kind_i == KindByte) && on_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE:   cmd_o.start_clr  = byte_acc && sts_i.start_match;
      ST_LENGTH: cmd_o.len_load   = byte_acc && sts_i.len_ok;
      ST_DATA:   cmd_o.data_store = byte_acc;
      ST_CHECK: begin
        cmd_o.sum_add = byte_acc;
        cmd_o.idx_clr = byte_acc && sts_i.sum_zero;
      end
      ST_READ:   cmd_o.rd_issue   = 1'b1;
      ST_LOAD:   cmd_o.out_load   = sts_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      on_q    <= 1'b1;
    end else begin
      if (acc && (in_kind_i == KindRearm)) begin
        on_q <= 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (byte_acc && sts_i.start_match) begin
            state_q <= ST_LENGTH;
          end
        end
        ST_LENGTH: begin
          if (byte_acc) begin
            state_q <= sts_i.len_ok ? ST_DATA : ST_IDLE;
          end
        end
        ST_DATA: begin
          if (byte_acc && sts_i.count_done) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (byte_acc) begin
            if (sts_i.sum_zero) begin
              on_q    <= 1'b0;
              state_q <= ST_READ;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_READ: state_q <= ST_LOAD;
        ST_LOAD: begin
          if (sts_i.out_free) begin
            state_q <= sts_i.drain_last ? ST_IDLE : ST_READ;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[design/checksummed_frame_receiver.sv]
// Top level of the checksummed frame receiver.
//
//  channel  dir  handshake                    content
//  cfg      in   cfg_valid_i/cfg_ready_o      start byte [7:0]
//  s_axis   in   s_axis_tvalid/s_axis_tready  tdata: rx_byte; tuser: kind
//  m_axis   out  m_axis_tvalid/m_axis_tready  tdata: byte,pos,length; tlast
//
// Received bytes and rearm words take one cycle each; s_axis_tready is low during a drain.
// A valid checksum byte starts a drain of the payload (up to 64 bytes): each byte is
// read from the registered payload memory, then loaded into the output register; input waits then.
// The output register lets the next word in while the final result is pending.
// Reset is asynchronous, active low; no memory clearing pass is needed.
module checksummed_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [13:8] byte_position,
                                      // [20:14] frame_length, [23:21] zero
  output logic        m_axis_tlast    // last
);
  import cfr_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [ByteW-1:0] out_byte;
  logic [IdxW-1:0]  out_pos;
  logic [LenW-1:0]  out_len;

  assign cfg_ready_o = 1'b1;

  cfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cfr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .rx_byte_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_byte_o  (out_byte),
    .out_pos_o   (out_pos),
    .out_len_o   (out_len),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_len, out_pos, out_byte};

endmodule

[design/cfr_checker.sv]
// Port-level checker for the frame receiver, with its bind.
`include "assert_macros.svh"

module cfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic [6:0] pos_inc;

  assign pos_inc = {1'b0, m_axis_tdata[13:8]} + 7'd1;

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  `ASSERT_IMPLY(a_last_pos, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, pos_inc == m_axis_tdata[20:14])
  `ASSERT_IMPLY(a_mid_pos, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, pos_inc < m_axis_tdata[20:14])
  `ASSERT_IMPLY(a_len_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[20:14] != 7'd0 && m_axis_tdata[20:14] <= 7'd64 && m_axis_tdata[23:21] == 3'd0)

endmodule

bind checksummed_frame_receiver cfr_checker u_cfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
